FILE: hdl/clbc_pkg.sv
package clbc_pkg;

  // card value and BCD image
  localparam int VALUE_W    = 63;
  localparam int NIB_W      = 4;
  localparam int BCD_DIGITS = 19;
  localparam int BCD_W      = BCD_DIGITS * NIB_W;

  // converter takes one nibble of the binary value per cycle
  localparam int CONV_STEPS = (VALUE_W + NIB_W - 1) / NIB_W;
  localparam int PAD_W      = CONV_STEPS * NIB_W;

  // result word
  localparam int BRAND_W = 2;
  localparam int COUNT_W = 5;

  localparam int MAX_DIGITS_DEF = 19;

  localparam logic [BRAND_W-1:0] BRAND_INVALID    = 2'd0;
  localparam logic [BRAND_W-1:0] BRAND_VISA       = 2'd1;
  localparam logic [BRAND_W-1:0] BRAND_AMEX       = 2'd2;
  localparam logic [BRAND_W-1:0] BRAND_MASTERCARD = 2'd3;

  typedef struct packed {
    logic [BRAND_W-1:0] brand;
    logic [COUNT_W-1:0] digit_count;
    logic               luhn_ok;
  } clbc_res_t;

endpackage

FILE: hdl/card_number_luhn_brand_check.sv
// An accepted input word goes through nibble-serial binary to BCD conversion,
//   then a digit-serial Luhn scan, then hand-over registers to out_*.
// No new word is taken until the scan has handed over the previous result word
//   and any parked copy of it has moved on to out_*.
// Reset: rst_n synchronous, active low; clears all control, no word in flight,
//   in_stall and out_valid low after reset.
module card_number_luhn_brand_check #(
  parameter int MAX_DIGITS = clbc_pkg::MAX_DIGITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [clbc_pkg::VALUE_W-1:0] in_card_value,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [clbc_pkg::BRAND_W-1:0] out_brand,
  output logic [clbc_pkg::COUNT_W-1:0] out_digit_count,
  output logic                         out_luhn_ok
);
  import clbc_pkg::*;

  // one word in flight at a time; busy from accept until the scan hands over
  logic             busy_r;
  logic             out_valid_r;
  logic             hold_valid_r;
  clbc_res_t        out_r;
  clbc_res_t        hold_r;

  logic             in_accept;
  logic             slot_free;
  logic             conv_done;
  logic [BCD_W-1:0] conv_bcd;
  logic             scan_done;
  clbc_res_t        scan_res;

  assign in_accept = in_valid && !in_stall;
  // a result word may be parked in hold_r while out_r is stalled; no new
  // word is taken until it has moved on
  assign in_stall  = busy_r || hold_valid_r;
  assign slot_free = !out_valid_r || !out_stall;

  // binary value to 19 BCD digits, four bits a cycle
  clbc_bin2bcd u_bin2bcd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_accept),
    .value (in_card_value),
    .done  (conv_done),
    .bcd   (conv_bcd)
  );

  // digit count, Luhn sum and leading digits, one digit a cycle, then brand
  clbc_scan #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .start (conv_done),
    .bcd   (conv_bcd),
    .done  (scan_done),
    .res   (scan_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r       <= 1'b0;
      out_valid_r  <= 1'b0;
      hold_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (scan_done) begin
        busy_r <= 1'b0;
      end

      if (scan_done) begin
        if (slot_free) begin
          out_valid_r <= 1'b1;
        end else begin
          hold_valid_r <= 1'b1;
        end
      end else if (hold_valid_r && slot_free) begin
        out_valid_r  <= 1'b1;
        hold_valid_r <= 1'b0;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // output word register and its skid copy
  always_ff @(posedge clk) begin
    if (scan_done) begin
      if (slot_free) begin
        out_r <= scan_res;
      end else begin
        hold_r <= scan_res;
      end
    end else if (hold_valid_r && slot_free) begin
      out_r <= hold_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_brand       = out_r.brand;
  assign out_digit_count = out_r.digit_count;
  assign out_luhn_ok     = out_r.luhn_ok;

  // a finished word only ever belongs to the word in flight
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (conv_done || scan_done) |-> busy_r)
    else $error("conversion or scan finished with no word in flight");

  // the skid copy is never needed twice
  a_hold_clash: assert property (@(posedge clk) disable iff (!rst_n)
    scan_done |-> !hold_valid_r)
    else $error("scan finished while a result word was parked");

  // a parked word implies the output register is still occupied
  a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
    hold_valid_r |-> out_valid_r)
    else $error("parked word with empty output register");

  // after an accept the input side is closed
  a_accept_close: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> in_stall)
    else $error("input open again straight after an accept");

endmodule

FILE: hdl/clbc_bin2bcd.sv
module clbc_bin2bcd (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic [clbc_pkg::VALUE_W-1:0] value,
  output logic                         done,
  output logic [clbc_pkg::BCD_W-1:0]   bcd
);
  import clbc_pkg::*;

  localparam int STEP_W = (CONV_STEPS > 1) ? $clog2(CONV_STEPS) : 1;
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(CONV_STEPS - 1);
  localparam logic [NIB_W-1:0] ADJ_LIMIT = NIB_W'(5);
  localparam logic [NIB_W-1:0] ADJ_ADD   = NIB_W'(3);

  logic              busy_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [PAD_W-1:0]  shreg_r;
  logic [BCD_W-1:0]  bcd_r;
  logic [BCD_W-1:0]  bcd_nxt;

  // double-dabble correction for one BCD digit
  function automatic logic [NIB_W-1:0] adj(input logic [NIB_W-1:0] d);
    return (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
  endfunction

  // four shift-and-correct steps per cycle, MSB of the binary value first
  always_comb begin
    bcd_nxt = bcd_r;
    for (int b = 0; b < NIB_W; b++) begin
      for (int k = 0; k < BCD_DIGITS; k++) begin
        bcd_nxt[k*NIB_W +: NIB_W] = adj(bcd_nxt[k*NIB_W +: NIB_W]);
      end
      bcd_nxt = {bcd_nxt[BCD_W-2:0], shreg_r[PAD_W-1-b]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end else if (busy_r) begin
        step_r <= step_r + 1'b1;
        if (step_r == STEP_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      shreg_r <= PAD_W'(value);
      bcd_r   <= '0;
    end else if (busy_r) begin
      shreg_r <= shreg_r << NIB_W;
      bcd_r   <= bcd_nxt;
    end
  end

  assign done = done_r;
  assign bcd  = bcd_r;

endmodule

FILE: hdl/clbc_scan.sv
module clbc_scan #(
  parameter int MAX_DIGITS = clbc_pkg::MAX_DIGITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [clbc_pkg::BCD_W-1:0] bcd,
  output logic                       done,
  output clbc_pkg::clbc_res_t        res
);
  import clbc_pkg::*;

  localparam logic [COUNT_W-1:0] POS_LIMIT = COUNT_W'(MAX_DIGITS);
  localparam logic [COUNT_W-1:0] POS_LAST  = COUNT_W'(BCD_DIGITS);
  localparam logic [COUNT_W-1:0] LEN_VISA_SHORT = COUNT_W'(13);
  localparam logic [COUNT_W-1:0] LEN_AMEX       = COUNT_W'(15);
  localparam logic [COUNT_W-1:0] LEN_LONG       = COUNT_W'(16);
  localparam logic [NIB_W-1:0] LEAD_VISA   = NIB_W'(4);
  localparam logic [NIB_W-1:0] LEAD_AMEX   = NIB_W'(3);
  localparam logic [NIB_W-1:0] AMEX_SEC_A  = NIB_W'(4);
  localparam logic [NIB_W-1:0] AMEX_SEC_B  = NIB_W'(7);
  localparam logic [NIB_W-1:0] LEAD_MC     = NIB_W'(5);
  localparam logic [NIB_W-1:0] MC_SEC_LO   = NIB_W'(1);
  localparam logic [NIB_W-1:0] MC_SEC_HI   = NIB_W'(5);
  localparam logic [NIB_W:0]   RADIX       = (NIB_W+1)'(10);
  localparam logic [NIB_W:0]   CAST_NINES  = (NIB_W+1)'(9);

  logic               busy_r;
  logic               fin_r;
  logic               done_r;
  logic [COUNT_W-1:0] pos_r;
  logic [BCD_W-1:0]   dig_r;
  logic [NIB_W-1:0]   sum_r;
  logic [COUNT_W-1:0] count_r;
  logic [NIB_W-1:0]   top_r;
  logic [NIB_W-1:0]   second_r;
  logic [NIB_W-1:0]   prev_r;
  logic               leftover_r;
  clbc_res_t          res_r;

  logic [NIB_W-1:0]   d;
  logic [NIB_W:0]     dbl;
  logic [NIB_W:0]     add;
  logic [NIB_W:0]     sum_ext;
  logic [NIB_W-1:0]   sum_nxt;
  logic               in_range;
  clbc_res_t          res_nxt;

  // one digit per cycle, least significant first; sum kept mod 10
  always_comb begin
    d        = dig_r[NIB_W-1:0];
    in_range = (pos_r <= POS_LIMIT);
    dbl      = {d, 1'b0};
    if (!pos_r[0]) begin
      add = (dbl >= RADIX) ? dbl - CAST_NINES : dbl;
    end else begin
      add = {1'b0, d};
    end
    sum_ext = {1'b0, sum_r} + add;
    sum_nxt = (sum_ext >= RADIX) ? NIB_W'(sum_ext - RADIX) : sum_ext[NIB_W-1:0];
  end

  // brand rules, only with a clean checksum and no digits beyond the limit
  always_comb begin
    res_nxt.digit_count = count_r;
    res_nxt.luhn_ok     = (sum_r == '0);
    res_nxt.brand       = BRAND_INVALID;
    if (res_nxt.luhn_ok && !leftover_r) begin
      if ((count_r == LEN_VISA_SHORT || count_r == LEN_LONG) && top_r == LEAD_VISA) begin
        res_nxt.brand = BRAND_VISA;
      end else if (count_r == LEN_AMEX && top_r == LEAD_AMEX &&
                   (second_r == AMEX_SEC_A || second_r == AMEX_SEC_B)) begin
        res_nxt.brand = BRAND_AMEX;
      end else if (count_r == LEN_LONG && top_r == LEAD_MC &&
                   second_r >= MC_SEC_LO && second_r <= MC_SEC_HI) begin
        res_nxt.brand = BRAND_MASTERCARD;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      fin_r  <= 1'b0;
      done_r <= fin_r;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && pos_r == POS_LAST) begin
        busy_r <= 1'b0;
        fin_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dig_r      <= bcd;
      pos_r      <= COUNT_W'(1);
      sum_r      <= '0;
      count_r    <= '0;
      top_r      <= '0;
      second_r   <= '0;
      prev_r     <= '0;
      leftover_r <= 1'b0;
    end else if (busy_r) begin
      dig_r  <= dig_r >> NIB_W;
      pos_r  <= pos_r + 1'b1;
      prev_r <= d;
      if (in_range) begin
        sum_r <= sum_nxt;
        if (d != '0) begin
          count_r  <= pos_r;
          top_r    <= d;
          second_r <= prev_r;
        end
      end else if (d != '0) begin
        // digits remain past the limit: every in-range place was taken
        leftover_r <= 1'b1;
        count_r    <= POS_LIMIT;
      end
    end
    if (fin_r) begin
      res_r <= res_nxt;
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule
